>>> rtl/serial_parallel_controller_registers_unit_assert.svh
// Assertion macros for the RTL of the controller register block; spcr_ctrl uses them.
`ifndef SERIAL_PARALLEL_CONTROLLER_REGISTERS_UNIT_ASSERT_SVH
`define SERIAL_PARALLEL_CONTROLLER_REGISTERS_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SPCR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define SPCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/spcr_pkg.sv
package spcr_pkg;

    localparam int CLOCK_WIDTH = 27;
    localparam int CFG_W       = 27;
    localparam int DVD_W       = (CLOCK_WIDTH > CFG_W) ? CLOCK_WIDTH : CFG_W;
    localparam int DIVR_W      = 12;
    localparam int CNT_W       = $clog2(DVD_W);
    localparam int BAUD_W      = 23;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(9830400);
    localparam logic [CLOCK_WIDTH-1:0] SYSCLK_RESET = CLOCK_WIDTH'(CFG_RESET >> 4);

    localparam logic [2:0] FUNC_CMD      = 3'd0;
    localparam logic [2:0] FUNC_PARAM    = 3'd1;
    localparam logic [2:0] FUNC_READ_PAR = 3'd2;
    localparam logic [2:0] FUNC_READ_SER = 3'd3;
    localparam logic [2:0] FUNC_TICK     = 3'd4;

    localparam logic [1:0] CMD_CLASS_PAR = 2'b10;
    localparam logic [1:0] CMD_CLASS_SYS = 2'b11;

    localparam logic [2:0] PAR_PRIME_SET_A = 3'd4;
    localparam logic [2:0] PAR_PRIME_SET_B = 3'd5;
    localparam logic [2:0] PAR_PRIME_CLR   = 3'd6;

    localparam int CMD_SERIAL_BIT = 7;
    localparam int CMD_CLEAR_BIT  = 5;
    localparam int CMD_MASK1_BIT  = 5;
    localparam int CMD_MASK2_BIT  = 4;

    localparam logic [2:0] PIDX_DIV_LO   = 3'd0;
    localparam logic [2:0] PIDX_DIV_HI   = 3'd1;
    localparam logic [2:0] PIDX_FORMAT   = 3'd5;
    localparam logic [2:0] PIDX_PRESCALE = 3'd7;

    localparam int PF_PRIME = 4;
    localparam int SF_TXE   = 2;

    localparam int BAUD_SHIFT = 3;
    localparam int DIV0_SHIFT = 15;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_RESULT
    } spcr_state_t;

    typedef struct packed {
        logic apply;
        logic load_out;
    } spcr_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic div_done;
    } spcr_stat_t;

endpackage

>>> rtl/spcr_div.sv
module spcr_div
    import spcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DIVR_W-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DVD_W-1:0]  quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DIVR_W-1:0] dvs_reg, dvs_next;
    logic [DIVR_W:0]   trial;
    logic              fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? DIVR_W'(trial - {1'b0, dvs_reg}) : DIVR_W'(trial);
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/spcr_dp.sv
module spcr_dp
    import spcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  spcr_cmd_t         cmd,
    output spcr_stat_t        stat,
    input  logic [2:0]        s_func,
    input  logic [7:0]        s_data_byte,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    output logic [7:0]        m_read_data,
    output logic [BAUD_W-1:0] m_baud_rate,
    output logic [3:0]        m_data_bits,
    output logic              m_two_stop_bits,
    output logic              m_parity_enable,
    output logic              m_even_parity,
    output logic [5:0]        m_serial_control,
    output logic [1:0]        m_parallel_masks,
    output logic              m_prime_out
);

    logic [CFG_W-1:0]       in_clk_reg;
    logic [2:0]             ptr_reg, ptr_next;
    logic [7:0]             div_lo_reg, div_lo_next;
    logic [3:0]             div_hi_reg, div_hi_next;
    logic [5:0]             serial_ctrl_reg, serial_ctrl_next;
    logic [5:0]             fmt_reg, fmt_next;
    logic                   prime_reg, prime_next;
    logic                   im1_reg, im1_next;
    logic                   im2_reg, im2_next;
    logic                   txe_reg, txe_next;
    logic [CLOCK_WIDTH-1:0] sysclk_reg, sysclk_next;
    logic [BAUD_W-1:0]      baud_reg, baud_next;
    logic                   to_baud_reg, to_baud_next;
    logic [7:0]             rd_reg, rd_next;

    logic                   is_param;
    logic                   baud_sel;
    logic                   presc_sel;
    logic [7:0]             new_lo;
    logic [3:0]             new_hi;
    logic [DIVR_W-1:0]      new_div;
    logic [3:0]             presc;
    logic                   need_div;
    logic [DVD_W-1:0]       dvd;
    logic [DIVR_W-1:0]      dvs;
    logic                   div_busy;
    logic                   div_done;
    logic [DVD_W-1:0]       quotient;

    always_comb begin
        is_param  = s_func == FUNC_PARAM;
        baud_sel  = is_param && (ptr_reg == PIDX_DIV_LO || ptr_reg == PIDX_DIV_HI);
        presc_sel = is_param && ptr_reg == PIDX_PRESCALE;
        new_lo    = (ptr_reg == PIDX_DIV_LO) ? s_data_byte : div_lo_reg;
        new_hi    = (ptr_reg == PIDX_DIV_HI) ? s_data_byte[3:0] : div_hi_reg;
        new_div   = {new_hi, new_lo};
        presc     = s_data_byte[3:0];
        need_div  = (baud_sel && new_div > DIVR_W'(1)) || (presc_sel && presc != 4'd0);
        dvd       = baud_sel ? DVD_W'(sysclk_reg) : DVD_W'(in_clk_reg);
        dvs       = baud_sel ? new_div : DIVR_W'(presc);
    end

    always_comb begin
        ptr_next         = ptr_reg;
        div_lo_next      = div_lo_reg;
        div_hi_next      = div_hi_reg;
        serial_ctrl_next = serial_ctrl_reg;
        fmt_next         = fmt_reg;
        prime_next       = prime_reg;
        im1_next         = im1_reg;
        im2_next         = im2_reg;
        txe_next         = txe_reg;
        sysclk_next      = sysclk_reg;
        baud_next        = baud_reg;
        to_baud_next     = to_baud_reg;
        rd_next          = rd_reg;
        if (cmd.apply) begin
            rd_next      = 8'd0;
            to_baud_next = baud_sel;
            case (s_func)
                FUNC_CMD: begin
                    if (!s_data_byte[CMD_SERIAL_BIT]) begin
                        serial_ctrl_next = s_data_byte[5:0];
                    end
                    case (s_data_byte[7:6])
                        CMD_CLASS_PAR: begin
                            case (s_data_byte[2:0])
                                PAR_PRIME_SET_A: prime_next = 1'b1;
                                PAR_PRIME_SET_B: prime_next = 1'b1;
                                PAR_PRIME_CLR:   prime_next = 1'b0;
                                default:         prime_next = prime_reg;
                            endcase
                            im1_next = s_data_byte[CMD_MASK1_BIT];
                            im2_next = s_data_byte[CMD_MASK2_BIT];
                        end
                        CMD_CLASS_SYS: begin
                            if (s_data_byte[CMD_CLEAR_BIT]) begin
                                serial_ctrl_next = '0;
                                fmt_next         = '0;
                                prime_next       = 1'b0;
                                im1_next         = 1'b0;
                                im2_next         = 1'b0;
                                txe_next         = 1'b0;
                            end else begin
                                ptr_next = s_data_byte[2:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_PARAM: begin
                    case (ptr_reg)
                        PIDX_DIV_LO, PIDX_DIV_HI: begin
                            div_lo_next = new_lo;
                            div_hi_next = new_hi;
                            if (new_div == '0) begin
                                baud_next = BAUD_W'(sysclk_reg >> DIV0_SHIFT);
                            end else if (new_div == DIVR_W'(1)) begin
                                baud_next = '0;
                            end
                        end
                        PIDX_FORMAT: fmt_next = s_data_byte[5:0];
                        PIDX_PRESCALE: begin
                            if (presc == 4'd0) begin
                                sysclk_next = CLOCK_WIDTH'(in_clk_reg >> 4);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_READ_PAR: rd_next = 8'(prime_reg) << PF_PRIME;
                FUNC_READ_SER: rd_next = 8'(txe_reg) << SF_TXE;
                FUNC_TICK:     txe_next = 1'b1;
                default: begin
                end
            endcase
        end else if (div_done) begin
            if (to_baud_reg) begin
                baud_next = BAUD_W'(quotient >> BAUD_SHIFT);
            end else begin
                sysclk_next = CLOCK_WIDTH'(quotient);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_clk_reg      <= CFG_RESET;
            div_lo_reg      <= '0;
            div_hi_reg      <= '0;
            serial_ctrl_reg <= '0;
            fmt_reg         <= '0;
            prime_reg       <= 1'b0;
            im1_reg         <= 1'b0;
            im2_reg         <= 1'b0;
            txe_reg         <= 1'b0;
            sysclk_reg      <= SYSCLK_RESET;
            baud_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                in_clk_reg <= cfg_wr_data;
            end
            div_lo_reg      <= div_lo_next;
            div_hi_reg      <= div_hi_next;
            serial_ctrl_reg <= serial_ctrl_next;
            fmt_reg         <= fmt_next;
            prime_reg       <= prime_next;
            im1_reg         <= im1_next;
            im2_reg         <= im2_next;
            txe_reg         <= txe_next;
            sysclk_reg      <= sysclk_next;
            baud_reg        <= baud_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        to_baud_reg <= to_baud_next;
        rd_reg      <= rd_next;
        if (cmd.load_out) begin
            m_read_data      <= rd_reg;
            m_baud_rate      <= baud_reg;
            m_data_bits      <= 4'd5 + {2'b00, fmt_reg[3:2]};
            m_two_stop_bits  <= fmt_reg[0];
            m_parity_enable  <= fmt_reg[4];
            m_even_parity    <= fmt_reg[5];
            m_serial_control <= serial_ctrl_reg;
            m_parallel_masks <= {im1_reg, im2_reg};
            m_prime_out      <= prime_reg;
        end
    end

    spcr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.apply && need_div),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    assign stat = '{need_div: need_div, div_busy: div_busy, div_done: div_done};

endmodule

>>> rtl/spcr_ctrl.sv
`include "serial_parallel_controller_registers_unit_assert.svh"

module spcr_ctrl
    import spcr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  spcr_stat_t stat,
    output spcr_cmd_t  cmd
);

    spcr_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.need_div ? ST_DIVIDE : ST_RESULT;
                end
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.apply    = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                cmd.apply = s_valid;
            end
            ST_RESULT: cmd.load_out = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `SPCR_ASSERT_SAME(a_idle_div_quiet, aclk, aresetn, state_reg == ST_IDLE, !stat.div_busy)
    `SPCR_ASSERT_SAME(a_done_in_divide, aclk, aresetn, stat.div_done, state_reg == ST_DIVIDE)
    `SPCR_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.load_out, m_valid_reg)
    `SPCR_ASSERT_NEXT(a_div_item_waits, aclk, aresetn, s_valid && s_ready && stat.need_div,
                      state_reg == ST_DIVIDE && stat.div_busy)

endmodule

>>> rtl/serial_parallel_controller_registers_unit.sv
// Register block of a combined serial and parallel port controller.
// The input channel (s_valid/s_ready) carries one beat per bus access: a
// function code and a data byte. Every accepted beat yields exactly one
// result beat on the output channel (m_valid/m_ready), holding the status
// byte for reads and the current line settings, baud rate and flags.
// The input clock register is written through cfg_wr_en/cfg_wr_data and is
// only used at the next prescaler write; reset reloads it with its default.
// A beat goes from acceptance to a valid result through the result state,
// or first through the divide state when a divisor write above 1 or a
// nonzero prescaler write starts the bit-serial divider, which retires one
// quotient bit per cycle; one beat is in work at a time.
// A finished result waits in the output register while the next beat is
// accepted; if the receiver stalls, the block holds the following result
// until the output register frees up and takes no further beat meanwhile.
// Synchronous reset clears all flags, control bits and divisor bytes, loads
// the input clock with 9830400 and the system clock with that value divided
// by 16, and leaves the parameter pointer undefined until written.
module serial_parallel_controller_registers_unit
    import spcr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_func,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_read_data,
    output logic [BAUD_W-1:0] m_baud_rate,
    output logic [3:0]        m_data_bits,
    output logic              m_two_stop_bits,
    output logic              m_parity_enable,
    output logic              m_even_parity,
    output logic [5:0]        m_serial_control,
    output logic [1:0]        m_parallel_masks,
    output logic              m_prime_out,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data
);

    spcr_cmd_t  cmd;
    spcr_stat_t stat;

    spcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    spcr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .s_func           (s_func),
        .s_data_byte      (s_data_byte),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .m_read_data      (m_read_data),
        .m_baud_rate      (m_baud_rate),
        .m_data_bits      (m_data_bits),
        .m_two_stop_bits  (m_two_stop_bits),
        .m_parity_enable  (m_parity_enable),
        .m_even_parity    (m_even_parity),
        .m_serial_control (m_serial_control),
        .m_parallel_masks (m_parallel_masks),
        .m_prime_out      (m_prime_out)
    );

endmodule

>>> test/serial_parallel_controller_registers_unit_tb.sv
`timescale 1ns / 100ps

module serial_parallel_controller_registers_unit_tb;
    import spcr_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RANDOM_ACCESSES = 1450;
    localparam int PHASES          = 5;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PF_MASK1        = 8;
    localparam int PF_MASK2        = 9;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
    localparam logic [7:0] CMD_FLAG_RESET   = 8'hE0;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [BAUD_W-1:0] baud_rate;
        logic [3:0]        data_bits;
        logic              two_stop_bits;
        logic              parity_enable;
        logic              even_parity;
        logic [5:0]        serial_control;
        logic [1:0]        parallel_masks;
        logic              prime_out;
    } line_status_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_func = FUNC_READ_PAR;
    logic [7:0]        s_data_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_read_data;
    logic [BAUD_W-1:0] m_baud_rate;
    logic [3:0]        m_data_bits;
    logic              m_two_stop_bits;
    logic              m_parity_enable;
    logic              m_even_parity;
    logic [5:0]        m_serial_control;
    logic [1:0]        m_parallel_masks;
    logic              m_prime_out;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    logic [CFG_W-1:0]       in_clk_hz = CFG_RESET;
    logic [CLOCK_WIDTH-1:0] sys_clk_hz = CLOCK_WIDTH'(CFG_RESET / 16);
    logic [2:0]             param_ptr = '0;
    logic [7:0]             param_bytes [8] = '{default: '0};
    logic [5:0]             ctl_bits = '0;
    logic [7:0]             format_bits = '0;
    logic [9:0]             par_flags = '0;
    logic [7:0]             ser_flags = '0;
    logic [BAUD_W-1:0]      baud_now = '0;

    line_status_t pending_status [$];
    int           mismatches = 0;
    int           beats_checked = 0;
    int           accesses_sent = 0;
    int           settings_used = 1;
    int           cycle_count = 0;
    int           stall_left = 0;
    bit           idle_on = 1'b1;

    serial_parallel_controller_registers_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_data     (m_read_data),
        .m_baud_rate     (m_baud_rate),
        .m_data_bits     (m_data_bits),
        .m_two_stop_bits (m_two_stop_bits),
        .m_parity_enable (m_parity_enable),
        .m_even_parity   (m_even_parity),
        .m_serial_control(m_serial_control),
        .m_parallel_masks(m_parallel_masks),
        .m_prime_out     (m_prime_out),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("serial_parallel_controller_registers_unit_tb: errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void refresh_baud();
        logic [11:0] divisor;
        logic [31:0] rate;
        divisor = {param_bytes[PIDX_DIV_HI][3:0], param_bytes[PIDX_DIV_LO]};
        if (divisor == 12'd0) begin
            rate = 32'(sys_clk_hz) / 32'd4096 / 32'd8;
        end else if (divisor == 12'd1) begin
            rate = '0;
        end else begin
            rate = 32'(sys_clk_hz) / 32'(divisor) / 32'd8;
        end
        baud_now = rate[BAUD_W-1:0];
    endfunction

    function automatic line_status_t apply_access(input logic [2:0] fn, input logic [7:0] d);
        line_status_t r;
        logic [3:0]   prescale;
        r.read_data = '0;
        case (fn)
            FUNC_CMD: begin
                if (!d[CMD_SERIAL_BIT]) ctl_bits = d[5:0];
                if (d[7:6] == CMD_CLASS_PAR) begin
                    case (d[2:0])
                        PAR_PRIME_SET_A, PAR_PRIME_SET_B: par_flags[PF_PRIME] = 1'b1;
                        PAR_PRIME_CLR: par_flags[PF_PRIME] = 1'b0;
                        default: if (!d[2]) par_flags[d[1:0]] = 1'b0;
                    endcase
                    par_flags[PF_MASK1] = d[CMD_MASK1_BIT];
                    par_flags[PF_MASK2] = d[CMD_MASK2_BIT];
                end else if (d[7:6] == CMD_CLASS_SYS) begin
                    if (d[CMD_CLEAR_BIT]) begin
                        ctl_bits = '0;
                        format_bits = '0;
                        par_flags = '0;
                        ser_flags = '0;
                    end else begin
                        param_ptr = d[2:0];
                    end
                end
            end
            FUNC_PARAM: begin
                param_bytes[param_ptr] = d;
                case (param_ptr)
                    PIDX_DIV_LO, PIDX_DIV_HI: refresh_baud();
                    PIDX_FORMAT: format_bits = d;
                    PIDX_PRESCALE: begin
                        prescale = d[3:0];
                        if (prescale == 4'd0) begin
                            sys_clk_hz = CLOCK_WIDTH'(32'(in_clk_hz) / 32'd16);
                        end else begin
                            sys_clk_hz = CLOCK_WIDTH'(32'(in_clk_hz) / 32'(prescale));
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_READ_PAR: r.read_data = par_flags[7:0];
            FUNC_READ_SER: r.read_data = ser_flags;
            FUNC_TICK: ser_flags[SF_TXE] = 1'b1;
            default: ;
        endcase
        r.baud_rate = baud_now;
        r.data_bits = 4'd5 + 4'(format_bits[3:2]);
        r.two_stop_bits = format_bits[0];
        r.parity_enable = format_bits[4];
        r.even_parity = format_bits[5];
        r.serial_control = ctl_bits;
        r.parallel_masks = {par_flags[PF_MASK1], par_flags[PF_MASK2]};
        r.prime_out = par_flags[PF_PRIME];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        line_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("result beat arrived with no access outstanding");
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                check_field("read_data", want.read_data, m_read_data);
                check_field("baud_rate", want.baud_rate, m_baud_rate);
                check_field("data_bits", want.data_bits, m_data_bits);
                check_field("two_stop_bits", want.two_stop_bits, m_two_stop_bits);
                check_field("parity_enable", want.parity_enable, m_parity_enable);
                check_field("even_parity", want.even_parity, m_even_parity);
                check_field("serial_control", want.serial_control, m_serial_control);
                check_field("parallel_masks", want.parallel_masks, m_parallel_masks);
                check_field("prime_out", want.prime_out, m_prime_out);
                beats_checked++;
            end
        end
    end

    task automatic send_access(input logic [2:0] fn, input logic [7:0] d);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_data_byte <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(apply_access(fn, d));
        accesses_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_input_clock(input logic [CFG_W-1:0] hz);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        in_clk_hz = hz;
        settings_used++;
    endtask

    task automatic test_reset_values();
        send_access(FUNC_READ_PAR, 8'hFF);
        send_access(FUNC_READ_SER, 8'h00);
        send_access(FUNC_SPARE_LAST, 8'hA5);
    endtask

    task automatic test_divisor_setup();
        send_access(FUNC_CMD, {CMD_CLASS_SYS, 3'b000, PIDX_DIV_HI});
        send_access(FUNC_PARAM, 8'hF0);
        send_access(FUNC_CMD, {CMD_CLASS_SYS, 3'b011, PIDX_DIV_LO});
        send_access(FUNC_PARAM, 8'h00);
        send_access(FUNC_PARAM, 8'h01);
    endtask

    task automatic test_prescaler();
        send_access(FUNC_CMD, {CMD_CLASS_SYS, 3'b000, PIDX_PRESCALE});
        send_access(FUNC_PARAM, 8'h01);
        send_access(FUNC_PARAM, 8'hFF);
    endtask

    task automatic test_line_format();
        send_access(FUNC_CMD, {CMD_CLASS_SYS, 3'b010, PIDX_FORMAT});
        send_access(FUNC_PARAM, 8'hFF);
        send_access(FUNC_PARAM, 8'h00);
    endtask

    task automatic test_serial_command();
        send_access(FUNC_CMD, 8'h7F);
    endtask

    task automatic test_parallel_commands();
        send_access(FUNC_CMD, {CMD_CLASS_PAR, 3'b110, PAR_PRIME_SET_A});
        send_access(FUNC_CMD, 8'h9F);
        send_access(FUNC_CMD, {CMD_CLASS_PAR, 3'b000, PAR_PRIME_CLR});
    endtask

    task automatic test_flag_reset();
        send_access(FUNC_TICK, 8'h00);
        send_access(FUNC_READ_SER, 8'h00);
        send_access(FUNC_CMD, {CMD_CLASS_PAR, 3'b000, PAR_PRIME_SET_B});
        send_access(FUNC_READ_PAR, 8'h00);
        send_access(FUNC_CMD, CMD_FLAG_RESET);
        send_access(FUNC_READ_SER, 8'h00);
    endtask

    task automatic send_random_access();
        int         pick;
        int         which;
        logic [2:0] ptr;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            which = $urandom_range(0, 11);
            case (which)
                8, 9: ptr = 3'(which - 8);
                10: ptr = PIDX_FORMAT;
                11: ptr = PIDX_PRESCALE;
                default: ptr = 3'(which);
            endcase
            send_access(FUNC_CMD, {CMD_CLASS_SYS, 1'b0, 2'($urandom), ptr});
            repeat ($urandom_range(1, 3)) send_access(FUNC_PARAM, 8'($urandom));
        end else if (pick < 50) begin
            send_access(FUNC_CMD, 8'($urandom));
        end else if (pick < 65) begin
            send_access(FUNC_PARAM, 8'($urandom));
        end else if (pick < 80) begin
            send_access(FUNC_READ_PAR, 8'($urandom));
        end else if (pick < 90) begin
            send_access(FUNC_READ_SER, 8'($urandom));
        end else if (pick < 97) begin
            send_access(FUNC_TICK, 8'($urandom));
        end else begin
            send_access(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), 8'($urandom));
        end
    endtask

    task automatic run_random_phase(input int count);
        int first;
        first = accesses_sent;
        while (accesses_sent - first < count) send_random_access();
    endtask

    initial begin
        logic [CFG_W-1:0] hz;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_divisor_setup();
        test_prescaler();
        test_line_format();
        test_serial_command();
        test_parallel_commands();
        test_flag_reset();
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: hz = CFG_W'(100000000);
                1: hz = CFG_W'(1);
                PHASES - 1: hz = CFG_RESET;
                default: hz = CFG_W'($urandom_range(1, 100000000));
            endcase
            write_input_clock(hz);
            if (ph == PHASES - 1) idle_on = 1'b0;
            run_random_phase(RANDOM_ACCESSES / PHASES);
        end
        wait_idle();
        $display("Run covered %0d accesses and %0d checked result beats over %0d clock settings.",
                 accesses_sent, beats_checked, settings_used);
        if (mismatches == 0) begin
            $display("serial_parallel_controller_registers_unit_tb: clean");
        end else begin
            $display("serial_parallel_controller_registers_unit_tb: errors");
        end
        $finish;
    end

endmodule
